// ----- hw/rtl/pressure_auto_zero_front_end_assert.svh -----
// assertion macros shared by the pressure auto-zero front end
`ifndef PRESSURE_AUTO_ZERO_FRONT_END_ASSERT_SVH
`define PRESSURE_AUTO_ZERO_FRONT_END_ASSERT_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define PAZ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("paz same-cycle check failed");

// next-cycle implication, checked on clk, off while arst_n is low
`define PAZ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("paz next-cycle check failed");

`endif

// ----- hw/rtl/paz_pkg.sv -----
// types, constants and widths of the pressure auto-zero front end
package paz_pkg;

	localparam int WINDOW = 20;
	localparam int SMP_W = 16;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SCAN_W = $clog2(WINDOW);
	localparam int SUM_W = SMP_W + 1 + $clog2(WINDOW);
	localparam int D_W = SUM_W + 1;
	localparam int ROUND_SHIFT = 5;
	localparam int N_W = D_W + ROUND_SHIFT + 1;
	localparam int DIVISOR = 2 * WINDOW;
	localparam int RECIP_SHIFT = N_W + $clog2(DIVISOR);
	localparam int RECIP_W = N_W + 1;
	localparam int QUO_W = N_W + RECIP_W - RECIP_SHIFT;
	localparam longint RECIP = ((longint'(1) <<< RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int OUT_W = 21;
	localparam int Q4_MAX = 1048575;
	localparam int Q4_MIN = -1048576;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [15:0] STABILITY_RST = 16'd120;
	localparam logic [15:0] DRIFT_RST = 16'd900;
	localparam logic [14:0] FOLD_RST = 15'd300;
	localparam logic signed [15:0] TEMP_LOW_RST = -16'sd8000;
	localparam logic signed [15:0] TEMP_HIGH_RST = 16'sd17000;

	typedef enum logic [2:0] {
		REG_STABILITY = 3'd0,
		REG_DRIFT = 3'd1,
		REG_FOLD = 3'd2,
		REG_TEMP_LOW = 3'd3,
		REG_TEMP_HIGH = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADOPT,
		ST_CORR,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [15:0] stability_limit;
		logic [15:0] drift_limit;
		logic [14:0] fold_limit;
		logic signed [15:0] temp_low;
		logic signed [15:0] temp_high;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] pressure_raw;
		logic signed [15:0] temperature_raw;
	} req_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pressure_q4;
		logic signed [15:0] temperature_out;
		logic sample_valid;
	} rsp_word_t;

	typedef struct packed {
		logic done;
		logic signed [QUO_W:0] quot;
	} div_res_t;

endpackage

// ----- hw/rtl/pressure_auto_zero_front_end.sv -----
// pressure auto-zero front end: sample chain, window scan, zero adoption and output
//
// channel   direction  handshake              word
// req       in         req_valid / req_ready  req_word_t  pressure_raw, temperature_raw
// rsp       out        rsp_valid / rsp_ready  rsp_word_t  pressure_q4, temperature_out,
//                                                         sample_valid
// apb       in / out   psel, penable, pready  five config registers at 4*index
//
// one word at a time: the controller runs SCAN, ADOPT, CORR and DIV with a full ring,
// CORR and DIV while the ring fills; the scan rotates the cell chain one cell per cycle and
// division by 2*WINDOW is a reciprocal multiply registered in mag_q, quo_q and quot_q;
// a finished result sits in the output register, so the next word is taken while it waits
// reset clears the fill count, the zero offset and the controller; ring cells are not cleared
module pressure_auto_zero_front_end import paz_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_word_t req_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_word_t rsp_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	`include "pressure_auto_zero_front_end_assert.svh"

	cfg_t cfg;
	state_t state_q, state_d;

	logic [CNT_W-1:0] fill_q;
	logic signed [SUM_W-1:0] off_q;
	logic [SCAN_W-1:0] scan_cnt_q;
	logic rsp_valid_q;
	rsp_word_t rsp_data_q;

	logic signed [SMP_W-1:0] p_q;
	logic signed [SMP_W-1:0] t_q;
	logic signed [SMP_W-1:0] mn_q;
	logic signed [SMP_W-1:0] mx_q;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [SMP_W-1:0] cell_data [WINDOW];
	logic signed [SMP_W-1:0] tail;
	logic signed [SMP_W-1:0] head_in;
	logic shift_en;
	logic scan_en;
	logic adopt_en;
	logic div_start;
	logic out_load;
	logic accept;
	logic slot_free;
	logic scan_last;
	logic fill_next_full;

	logic signed [SMP_W:0] spread;
	logic stable;
	logic signed [SUM_W:0] diff;
	logic [SUM_W:0] drift_mag;
	logic [SUM_W-1:0] drift_w;
	logic near;

	logic signed [D_W-1:0] pw;
	logic signed [D_W-1:0] dd;
	logic [D_W-1:0] fold_w;
	logic signed [D_W-1:0] fold_neg;
	logic signed [D_W-1:0] dfold;
	logic signed [N_W-1:0] num;

	div_res_t div_res;
	logic signed [OUT_W-1:0] pq_sat;

	paz_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// sample chain: shifts in a new word, rotates through the tail during the scan
	assign tail = cell_data[WINDOW-1];
	assign head_in = req_ready ? req_data.pressure_raw : tail;

	for (genvar i = 0; i < WINDOW; i++) begin : g_chain
		if (i == 0) begin : g_head
			paz_cell u_cell (
				.clk(clk),
				.shift(shift_en),
				.din(head_in),
				.dout(cell_data[i])
			);
		end else begin : g_body
			paz_cell u_cell (
				.clk(clk),
				.shift(shift_en),
				.din(cell_data[i-1]),
				.dout(cell_data[i])
			);
		end
	end

	assign accept = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign scan_last = scan_cnt_q == SCAN_W'(WINDOW - 1);
	assign fill_next_full = fill_q >= CNT_W'(WINDOW - 1);

	// plateau and drift tests
	always_comb begin
		spread = (SMP_W+1)'(mx_q) - (SMP_W+1)'(mn_q);
		stable = $unsigned(spread) < (SMP_W+1)'(cfg.stability_limit);
		diff = (SUM_W+1)'(sum_q) - (SUM_W+1)'(off_q);
		drift_mag = diff[SUM_W] ? $unsigned(-diff) : $unsigned(diff);
		drift_w = SUM_W'(cfg.drift_limit) * SUM_W'(WINDOW);
		near = drift_mag < (SUM_W+1)'(drift_w);
	end

	// corrected value times WINDOW, folded, then scaled for rounding
	always_comb begin
		pw = D_W'(p_q) * D_W'(WINDOW);
		dd = pw - D_W'(off_q);
		fold_w = D_W'(cfg.fold_limit) * D_W'(WINDOW);
		fold_neg = -$signed(fold_w);
		dfold = (dd < fold_neg) ? -dd : dd;
		num = (N_W'(dfold) <<< ROUND_SHIFT) + N_W'(WINDOW);
	end

	paz_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num),
		.res(div_res)
	);

	always_comb begin
		if (div_res.quot > (QUO_W+1)'(Q4_MAX)) begin
			pq_sat = OUT_W'(Q4_MAX);
		end else if (div_res.quot < (QUO_W+1)'(Q4_MIN)) begin
			pq_sat = OUT_W'(Q4_MIN);
		end else begin
			pq_sat = OUT_W'(div_res.quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		shift_en = 1'b0;
		scan_en = 1'b0;
		adopt_en = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					shift_en = 1'b1;
					state_d = fill_next_full ? ST_SCAN : ST_CORR;
				end
			end
			ST_SCAN: begin
				shift_en = 1'b1;
				scan_en = 1'b1;
				if (scan_last) begin
					state_d = ST_ADOPT;
				end
			end
			ST_ADOPT: begin
				adopt_en = stable && near;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (slot_free) begin
						out_load = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			off_q <= '0;
			scan_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				scan_cnt_q <= '0;
				if (fill_q != CNT_W'(WINDOW)) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (scan_en) begin
				scan_cnt_q <= scan_cnt_q + SCAN_W'(1);
			end
			if (adopt_en) begin
				off_q <= sum_q;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= req_data.pressure_raw;
			t_q <= req_data.temperature_raw;
		end
		if (scan_en) begin
			if (scan_cnt_q == '0) begin
				mn_q <= tail;
				mx_q <= tail;
				sum_q <= SUM_W'(tail);
			end else begin
				mn_q <= (tail < mn_q) ? tail : mn_q;
				mx_q <= (tail > mx_q) ? tail : mx_q;
				sum_q <= sum_q + SUM_W'(tail);
			end
		end
		if (out_load) begin
			rsp_data_q.pressure_q4 <= pq_sat;
			rsp_data_q.temperature_out <= t_q;
			rsp_data_q.sample_valid <= (t_q >= cfg.temp_low) && (t_q <= cfg.temp_high);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_data_q;

	`PAZ_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_q == ST_SCAN || state_q == ST_CORR)
	`PAZ_ASSERT_IMPL(a_scan_needs_full, state_q == ST_SCAN, fill_q == CNT_W'(WINDOW))
	`PAZ_ASSERT_IMPL(a_done_in_div, div_res.done, state_q == ST_DIV)
	`PAZ_ASSERT_NEXT(a_scan_end, state_q == ST_SCAN && scan_last, state_q == ST_ADOPT)

endmodule

// ----- hw/rtl/paz_cell.sv -----
// one cell of the sample chain, holds one pressure sample
module paz_cell import paz_pkg::*; (
	input logic clk,
	input logic shift,
	input logic signed [SMP_W-1:0] din,
	output logic signed [SMP_W-1:0] dout
);

	logic signed [SMP_W-1:0] smp_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			smp_q <= din;
		end
	end

	assign dout = smp_q;

endmodule

// ----- hw/rtl/paz_div.sv -----
// floor division by twice the window length through a reciprocal multiply
module paz_div import paz_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [N_W-1:0] num,
	output div_res_t res
);

	logic mul_q;
	logic fin_q;
	logic done_q;
	logic neg_q;
	logic [N_W-1:0] mag_q;
	logic [QUO_W-1:0] quo_q;
	logic signed [QUO_W:0] quot_q;

	logic signed [N_W:0] neg_mag;
	logic [N_W-1:0] mag;
	logic [N_W+RECIP_W-1:0] prod;

	// negative dividend: floor(n/m) = -floor((m - 1 - n) / m)
	always_comb begin
		neg_mag = (N_W+1)'(DIVISOR - 1) - (N_W+1)'(num);
		mag = num[N_W-1] ? N_W'(neg_mag) : $unsigned(num);
	end

	// rounded-up reciprocal, exact floor for every magnitude of N_W bits
	assign prod = (N_W+RECIP_W)'(mag_q) * (N_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q <= start;
			fin_q <= mul_q;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[N_W-1];
			mag_q <= mag;
		end
		if (mul_q) begin
			quo_q <= prod[N_W+RECIP_W-1:RECIP_SHIFT];
		end
		if (fin_q) begin
			quot_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule

// ----- hw/rtl/paz_regs.sv -----
// configuration register file behind the apb port
module paz_regs import paz_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stability_limit <= STABILITY_RST;
			cfg_q.drift_limit <= DRIFT_RST;
			cfg_q.fold_limit <= FOLD_RST;
			cfg_q.temp_low <= TEMP_LOW_RST;
			cfg_q.temp_high <= TEMP_HIGH_RST;
		end else if (wr) begin
			unique case (idx)
				REG_STABILITY: cfg_q.stability_limit <= pwdata[15:0];
				REG_DRIFT: cfg_q.drift_limit <= pwdata[15:0];
				REG_FOLD: cfg_q.fold_limit <= pwdata[14:0];
				REG_TEMP_LOW: cfg_q.temp_low <= $signed(pwdata[15:0]);
				REG_TEMP_HIGH: cfg_q.temp_high <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STABILITY: prdata = DATA_W'(cfg_q.stability_limit);
			REG_DRIFT: prdata = DATA_W'(cfg_q.drift_limit);
			REG_FOLD: prdata = DATA_W'(cfg_q.fold_limit);
			REG_TEMP_LOW: prdata = DATA_W'(cfg_q.temp_low);
			REG_TEMP_HIGH: prdata = DATA_W'(cfg_q.temp_high);
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- tb/paz_word_checker.sv -----
// word checker for the pressure auto-zero front end: tracks config, predicts and compares rsp words
module paz_word_checker import paz_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_word_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_word_t rsp_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	output int errors,
	output int pending
);

	logic signed [SMP_W-1:0] window_ring [WINDOW];
	int ring_pos;
	int ring_fill;
	longint zero_sum;
	cfg_t cfg;
	rsp_word_t expected_words [$];
	rsp_word_t want;

	function automatic rsp_word_t auto_zero(input req_word_t w);
		longint lo;
		longint hi;
		longint sum;
		longint drift_mag;
		longint x;
		longint n;
		longint q;
		rsp_word_t o;
		window_ring[ring_pos] = w.pressure_raw;
		ring_pos = (ring_pos + 1) % WINDOW;
		if (ring_fill < WINDOW)
			ring_fill++;
		if (ring_fill == WINDOW) begin
			lo = window_ring[0];
			hi = window_ring[0];
			sum = 0;
			for (int i = 0; i < WINDOW; i++) begin
				if (window_ring[i] < lo)
					lo = window_ring[i];
				if (window_ring[i] > hi)
					hi = window_ring[i];
				sum += window_ring[i];
			end
			drift_mag = sum - zero_sum;
			if (drift_mag < 0)
				drift_mag = -drift_mag;
			// flat plateau close enough to the current zero becomes the new zero
			if (hi - lo < longint'(cfg.stability_limit) &&
					drift_mag < longint'(cfg.drift_limit) * WINDOW)
				zero_sum = sum;
		end
		// corrected value scaled by 16 * WINDOW, kept exact until the rounding divide
		x = 16 * (longint'($signed(w.pressure_raw)) * WINDOW - zero_sum);
		if (x < -16 * longint'(cfg.fold_limit) * WINDOW)
			x = -x;
		n = 2 * x + WINDOW;
		q = n / (2 * WINDOW);
		if (n % (2 * WINDOW) != 0 && n < 0)
			q--;
		if (q > Q4_MAX)
			q = Q4_MAX;
		if (q < Q4_MIN)
			q = Q4_MIN;
		o.pressure_q4 = OUT_W'(q);
		o.temperature_out = w.temperature_raw;
		o.sample_valid = ($signed(w.temperature_raw) >= $signed(cfg.temp_low)) &&
			($signed(w.temperature_raw) <= $signed(cfg.temp_high));
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pos = 0;
			ring_fill = 0;
			zero_sum = 0;
			cfg = '{STABILITY_RST, DRIFT_RST, FOLD_RST, TEMP_LOW_RST, TEMP_HIGH_RST};
			expected_words.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_STABILITY: cfg.stability_limit = pwdata[15:0];
					REG_DRIFT: cfg.drift_limit = pwdata[15:0];
					REG_FOLD: cfg.fold_limit = pwdata[14:0];
					REG_TEMP_LOW: cfg.temp_low = pwdata[15:0];
					REG_TEMP_HIGH: cfg.temp_high = pwdata[15:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					$error("rsp word with no word expected: pressure_q4 %0d",
						rsp_data.pressure_q4);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (rsp_data.pressure_q4 !== want.pressure_q4) begin
						$error("pressure_q4: expected %0d, got %0d",
							want.pressure_q4, rsp_data.pressure_q4);
						errors++;
					end
					if (rsp_data.temperature_out !== want.temperature_out) begin
						$error("temperature_out: expected %0d, got %0d",
							want.temperature_out, rsp_data.temperature_out);
						errors++;
					end
					if (rsp_data.sample_valid !== want.sample_valid) begin
						$error("sample_valid: expected %0d, got %0d",
							want.sample_valid, rsp_data.sample_valid);
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_words.push_back(auto_zero(req_data));
			pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// top of the pressure auto-zero front end testbench: clock, reset, stimulus and verdict
module testbench;
	import paz_pkg::*;

	localparam int NO_REG = 5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	int errors;
	int pending;

	int send_idle = 26;
	int recv_idle = 55;
	bit hold_rsp = 1'b0;
	int center = 0;
	int t_lo = -8000;
	int t_hi = 17000;

	pressure_auto_zero_front_end dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	paz_word_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic write_reg(input int idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int stab, input int drift, input int fold, input int lo,
			input int hi);
		write_reg(REG_STABILITY, stab);
		write_reg(REG_DRIFT, drift);
		write_reg(REG_FOLD, fold);
		write_reg(REG_TEMP_LOW, lo);
		write_reg(REG_TEMP_HIGH, hi);
		t_lo = lo;
		t_hi = hi;
	endtask

	task automatic send_word(input int p, input int t);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{pressure_raw: 16'(p), temperature_raw: 16'(t)};
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly plateaus of random level and jitter, with bursts of noise between them
	task automatic send_random(input int count);
		int left;
		int run;
		int c;
		int j;
		int p;
		int t;
		left = count;
		c = center;
		while (left > 0) begin
			if ($urandom_range(9) < 7) begin
				run = $urandom_range(45, 20);
				case ($urandom_range(5))
					0: c = int'($signed(16'($urandom)));
					1: c = ($urandom_range(1)) ? 32767 : -32768;
					default: c = center + int'($urandom_range(1600)) - 800;
				endcase
				if (c > 32767)
					c = 32767;
				if (c < -32768)
					c = -32768;
				j = ($urandom_range(4) == 0) ? int'($urandom_range(2000)) : int'($urandom_range(70));
				center = c;
			end else begin
				run = $urandom_range(8, 1);
				j = -1;
			end
			for (int k = 0; k < run && left > 0; k++) begin
				if (j < 0) begin
					p = int'($signed(16'($urandom)));
				end else begin
					p = c + int'($urandom_range(2 * j)) - j;
					if (p > 32767)
						p = 32767;
					if (p < -32768)
						p = -32768;
				end
				case ($urandom_range(3))
					0, 1: t = int'($signed(16'($urandom)));
					2: t = t_lo + int'($urandom_range(2)) - 1;
					default: t = t_hi + int'($urandom_range(2)) - 1;
				endcase
				send_word(p, t);
				left--;
			end
		end
	endtask

	// receiver: random ready, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		#8000000;
		$display("FAIL pressure_auto_zero_front_end");
		$finish;
	end

	initial begin
		int dir_p [8] = '{32767, -32768, 0, -1, 1, -300, -301, -299};
		int dir_t [8] = '{-32768, 32767, -8000, -8001, 17000, 17001, 0, -1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset config: field extremes, fold edge, temperature limits, then a plateau
		for (int k = 0; k < 8; k++)
			send_word(dir_p[k], dir_t[k]);
		for (int k = 0; k < 20; k++)
			send_word(500 + int'($urandom_range(60)) - 30, int'($urandom_range(5000)));
		center = 500;
		send_random(200);

		// widest limits, fold everything negative, full temperature span
		wait_idle();
		set_config(65535, 65535, 0, -32768, 32767);
		write_reg(NO_REG, 16'h1234);
		repeat (20) send_word(32767, 0);
		send_word(-32768, 0);
		repeat (20) send_word(-32768, 100);
		send_word(32767, -1);
		send_random(200);

		// no adoption possible, widest fold limit, crossed temperature limits
		wait_idle();
		set_config(0, 0, 32767, 32767, -32768);
		send_random(150);

		send_idle = 55;
		recv_idle = 26;
		wait_idle();
		set_config($urandom_range(300), $urandom_range(2000), $urandom_range(32767),
			-int'($urandom_range(12000)), $urandom_range(20000));
		send_random(200);

		// receiver stalls long while words keep coming
		wait_idle();
		hold_rsp = 1'b1;
		send_idle = 0;
		send_random(40);
		send_idle = 55;

		wait_idle();
		set_config($urandom_range(65535), $urandom_range(65535), $urandom_range(32767),
			int'($signed(16'($urandom))), int'($signed(16'($urandom))));
		send_random(200);

		send_idle = 0;
		recv_idle = 0;
		wait_idle();
		set_config($urandom_range(300), $urandom_range(3000), $urandom_range(2000),
			-int'($urandom_range(12000)), $urandom_range(20000));
		send_random(250);

		wait_idle();
		set_config(STABILITY_RST, DRIFT_RST, FOLD_RST, TEMP_LOW_RST, TEMP_HIGH_RST);
		send_random(300);

		wait_idle();
		set_config($urandom_range(200), $urandom_range(1500), $urandom_range(1000),
			-int'($urandom_range(32768)), $urandom_range(32767));
		send_random(250);

		wait_idle();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS pressure_auto_zero_front_end");
		else
			$display("FAIL pressure_auto_zero_front_end");
		$finish;
	end

endmodule
